[rtl/core/cdq_pkg.sv]
// Shared types and constants of the circular deque unit.
package cdq_pkg;

  localparam int unsigned DefaultDepth = 128;
  localparam int unsigned DataW        = 32;
  localparam int unsigned CmdW         = 3;

  localparam logic signed [DataW-1:0] EmptyValue = -32'sd1;

  typedef logic signed [DataW-1:0] cdq_data_t;

  typedef enum logic [CmdW-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_REAR  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_REAR   = 3'd3,
    CMD_REPORT     = 3'd4
  } cdq_cmd_e;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } cdq_state_e;

endpackage

[rtl/core/cdq_in_if.sv]
// Input channel of the circular deque unit: command and data word.
interface cdq_in_if import cdq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CmdW-1:0]      cmd;
  logic signed [DataW-1:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

[rtl/core/cdq_out_if.sv]
// Output channel of the circular deque unit: end values and status flags.
interface cdq_out_if import cdq_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] front_value;
  logic signed [DataW-1:0] rear_value;
  logic                    is_empty;
  logic                    is_full;
  logic                    rejected;

  modport source (output valid, output front_value, output rear_value, output is_empty,
                  output is_full, output rejected, input ready);
  modport sink   (input valid, input front_value, input rear_value, input is_empty,
                  input is_full, input rejected, output ready);
endinterface

[rtl/core/circular_deque_unit.sv]
// Top level of the circular deque unit: control, cached end values and result register.
//
//   channel  | direction | payload
//   ---------+-----------+-------------------------------------------------
//   in_i     | in        | cmd, value
//   out_o    | out       | front_value, rear_value, is_empty, is_full, rejected
//
// Pushes, refused commands, reports, unused codes and a pop of the last element
// load the result straight from the idle state. A pop that exposes a new end passes
// through the read state: the new end word comes from the ring store, whose read data is registered.
// Reset leaves the deque empty; the store itself is not cleared.
// A result waits in the output register; a new transaction is taken in the same
// cycle that the waiting result is taken.
module circular_deque_unit import cdq_pkg::*; #(
  parameter int unsigned Depth = DefaultDepth
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  cdq_in_if.sink  in_i,
  cdq_out_if.source out_o
);

  localparam int unsigned     IdxW    = $clog2(Depth);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Depth - 1);

  function automatic logic [IdxW-1:0] idx_next(input logic [IdxW-1:0] i);
    return (i == LastIdx) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IdxW-1:0] idx_prev(input logic [IdxW-1:0] i);
    return (i == '0) ? LastIdx : i - 1'b1;
  endfunction

  cdq_state_e      state_q, state_d;
  logic [IdxW-1:0] head_q, head_d, tail_q, tail_d;
  logic            holds_q, holds_d;
  cdq_data_t       front_q, front_d, rear_q, rear_d;
  logic            rd_front_q, rd_front_d;
  logic            rej_q, rej_d;

  logic            out_valid_q, out_valid_d;
  cdq_data_t       out_front_q, out_front_d, out_rear_q, out_rear_d;
  logic            out_empty_q, out_empty_d, out_full_q, out_full_d, out_rej_q, out_rej_d;

  logic            in_fire, out_free, full_cur, full_nxt;
  logic            rd_req, rej_now;
  logic            we;
  logic [IdxW-1:0] waddr, raddr;
  cdq_data_t       rdata;
  logic [IdxW-1:0] n_head, n_tail;
  logic            n_holds;
  cdq_data_t       n_front, n_rear;

  cdq_ram #(.Depth(Depth), .IdxW(IdxW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (in_i.value),
    .re_i    (rd_req),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign out_free   = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE) && out_free;
  assign in_fire    = in_i.valid && in_i.ready;
  assign full_cur   = holds_q && (idx_next(tail_q) == head_q);

  // Command decode: next indices, store write and the read of a newly exposed end.
  always_comb begin
    n_head  = head_q;
    n_tail  = tail_q;
    n_holds = holds_q;
    n_front = front_q;
    n_rear  = rear_q;
    rej_now = 1'b0;
    rd_req  = 1'b0;
    rd_front_d = rd_front_q;
    we      = 1'b0;
    waddr   = '0;
    raddr   = '0;
    if (in_fire) begin
      unique case (in_i.cmd)
        CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
          if (full_cur) begin
            rej_now = 1'b1;
          end else if (!holds_q) begin
            n_head  = '0;
            n_tail  = '0;
            n_holds = 1'b1;
            n_front = in_i.value;
            n_rear  = in_i.value;
            we      = 1'b1;
            waddr   = '0;
          end else if (in_i.cmd == CMD_PUSH_FRONT) begin
            n_head  = idx_prev(head_q);
            n_front = in_i.value;
            we      = 1'b1;
            waddr   = n_head;
          end else begin
            n_tail  = idx_next(tail_q);
            n_rear  = in_i.value;
            we      = 1'b1;
            waddr   = n_tail;
          end
        end
        CMD_POP_FRONT, CMD_POP_REAR: begin
          if (!holds_q) begin
            rej_now = 1'b1;
          end else if (head_q == tail_q) begin
            n_holds = 1'b0;
            n_head  = '0;
            n_tail  = '0;
          end else if (in_i.cmd == CMD_POP_FRONT) begin
            n_head     = idx_next(head_q);
            rd_req     = 1'b1;
            raddr      = n_head;
            rd_front_d = 1'b1;
          end else begin
            n_tail     = idx_prev(tail_q);
            rd_req     = 1'b1;
            raddr      = n_tail;
            rd_front_d = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign full_nxt = n_holds && (idx_next(n_tail) == n_head);

  // Sequencer and result register.
  always_comb begin
    state_d     = state_q;
    head_d      = n_head;
    tail_d      = n_tail;
    holds_d     = n_holds;
    front_d     = n_front;
    rear_d      = n_rear;
    rej_d       = rej_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_front_d = out_front_q;
    out_rear_d  = out_rear_q;
    out_empty_d = out_empty_q;
    out_full_d  = out_full_q;
    out_rej_d   = out_rej_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (rd_req) begin
            state_d = ST_READ;
            rej_d   = rej_now;
          end else begin
            out_valid_d = 1'b1;
            out_front_d = n_holds ? n_front : EmptyValue;
            out_rear_d  = n_holds ? n_rear : EmptyValue;
            out_empty_d = !n_holds;
            out_full_d  = full_nxt;
            out_rej_d   = rej_now;
          end
        end
      end
      ST_READ: begin
        // A read only follows a pop that leaves the deque non-empty.
        if (rd_front_q) begin
          front_d = rdata;
        end else begin
          rear_d = rdata;
        end
        state_d     = ST_IDLE;
        out_valid_d = 1'b1;
        out_front_d = rd_front_q ? rdata : front_q;
        out_rear_d  = rd_front_q ? rear_q : rdata;
        out_empty_d = 1'b0;
        out_full_d  = full_cur;
        out_rej_d   = rej_q;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      holds_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      holds_q     <= holds_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    front_q     <= front_d;
    rear_q      <= rear_d;
    rd_front_q  <= rd_front_d;
    rej_q       <= rej_d;
    out_front_q <= out_front_d;
    out_rear_q  <= out_rear_d;
    out_empty_q <= out_empty_d;
    out_full_q  <= out_full_d;
    out_rej_q   <= out_rej_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.front_value = out_front_q;
  assign out_o.rear_value  = out_rear_q;
  assign out_o.is_empty    = out_empty_q;
  assign out_o.is_full     = out_full_q;
  assign out_o.rejected    = out_rej_q;

endmodule

[rtl/core/cdq_ram.sv]
// Ring store: one write port and one read port with registered read data.
module cdq_ram import cdq_pkg::*; #(
  parameter int unsigned Depth = DefaultDepth,
  parameter int unsigned IdxW  = $clog2(Depth)
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [IdxW-1:0] waddr_i,
  input  cdq_data_t       wdata_i,
  input  logic            re_i,
  input  logic [IdxW-1:0] raddr_i,
  output cdq_data_t       rdata_o
);

  cdq_data_t mem [Depth];
  cdq_data_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[tb/circular_deque_unit_test.sv]
// Self-checking testbench of the circular deque unit with a shadow deque as predictor.
module circular_deque_unit_test;
  import cdq_pkg::*;

  localparam int unsigned IdxW       = $clog2(DefaultDepth);
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 300;

  typedef struct {
    cdq_data_t front;
    cdq_data_t rear;
    logic      empty;
    logic      full;
    logic      rejected;
  } deque_view_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  cdq_in_if  in_if ();
  cdq_out_if out_if ();

  circular_deque_unit dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the deque contents and pointers.
  cdq_data_t       shadow_store [DefaultDepth];
  logic [IdxW-1:0] shadow_head = '0;
  logic [IdxW-1:0] shadow_tail = '0;
  logic            shadow_busy = 1'b0;

  deque_view_t expected_views[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_gap_pct = 6;
  int unsigned recv_gap_pct = 76;
  logic        hold_active = 1'b0;
  event        start_hold;

  function automatic logic [IdxW-1:0] idx_after(logic [IdxW-1:0] i);
    return (i == IdxW'(DefaultDepth - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IdxW-1:0] idx_before(logic [IdxW-1:0] i);
    return (i == '0) ? IdxW'(DefaultDepth - 1) : i - 1'b1;
  endfunction

  function automatic logic shadow_full();
    return shadow_busy && (idx_after(shadow_tail) == shadow_head);
  endfunction

  // Applies one command to the shadow deque and returns the view it leaves.
  function automatic deque_view_t apply_command(logic [CmdW-1:0] c, cdq_data_t v);
    deque_view_t view;
    view.rejected = 1'b0;
    case (c)
      CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
        if (shadow_full()) begin
          view.rejected = 1'b1;
        end else if (!shadow_busy) begin
          shadow_head = '0;
          shadow_tail = '0;
          shadow_store[0] = v;
          shadow_busy = 1'b1;
        end else if (c == CMD_PUSH_FRONT) begin
          shadow_head = idx_before(shadow_head);
          shadow_store[shadow_head] = v;
        end else begin
          shadow_tail = idx_after(shadow_tail);
          shadow_store[shadow_tail] = v;
        end
      end
      CMD_POP_FRONT, CMD_POP_REAR: begin
        if (!shadow_busy) begin
          view.rejected = 1'b1;
        end else if (shadow_head == shadow_tail) begin
          shadow_busy = 1'b0;
          shadow_head = '0;
          shadow_tail = '0;
        end else if (c == CMD_POP_FRONT) begin
          shadow_head = idx_after(shadow_head);
        end else begin
          shadow_tail = idx_before(shadow_tail);
        end
      end
      default: ;
    endcase
    view.front = shadow_busy ? shadow_store[shadow_head] : EmptyValue;
    view.rear  = shadow_busy ? shadow_store[shadow_tail] : EmptyValue;
    view.empty = !shadow_busy;
    view.full  = shadow_full();
    return view;
  endfunction

  task automatic report_mismatch(string what, logic [DataW-1:0] got, logic [DataW-1:0] want);
    $display("%0t: %s got %h, expected %h", $time, what, got, want);
    error_count++;
  endtask

  // Offers one command, with a random gap before it, and waits until it is taken.
  task automatic send_command(logic [CmdW-1:0] c, cdq_data_t v);
    @(negedge clk_i);
    while ($urandom_range(99) < send_gap_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid = 1'b1;
    in_if.cmd   = c;
    in_if.value = v;
    do @(posedge clk_i); while (!in_if.ready);
    expected_views.push_back(apply_command(c, v));
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    in_if.valid = 1'b0;
  endtask

  // Receiver: random ready, forced low while a hold-off runs.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_if.ready = rst_ni && !hold_active && ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // Hold-off stretch of the receiver, started by the tests.
  initial begin
    forever begin
      @(start_hold);
      hold_active = 1'b1;
      repeat (HoldCycles) @(posedge clk_i);
      hold_active = 1'b0;
    end
  end

  always @(posedge clk_i) begin
    deque_view_t want;
    if (out_if.valid && out_if.ready) begin
      if (expected_views.size() == 0) begin
        report_mismatch("unexpected result, front", out_if.front_value, EmptyValue);
      end else begin
        want = expected_views.pop_front();
        if (out_if.front_value !== want.front)
          report_mismatch("front_value", out_if.front_value, want.front);
        if (out_if.rear_value !== want.rear)
          report_mismatch("rear_value", out_if.rear_value, want.rear);
        if (out_if.is_empty !== want.empty)
          report_mismatch("is_empty", DataW'(out_if.is_empty), DataW'(want.empty));
        if (out_if.is_full !== want.full)
          report_mismatch("is_full", DataW'(out_if.is_full), DataW'(want.full));
        if (out_if.rejected !== want.rejected)
          report_mismatch("rejected", DataW'(out_if.rejected), DataW'(want.rejected));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("circular_deque_unit: mismatch");
      $finish;
    end
  end

  function automatic cdq_data_t pick_value();
    case ($urandom_range(15))
      0:       return cdq_data_t'(32'h8000_0000);
      1:       return cdq_data_t'(32'h7fff_ffff);
      2:       return '0;
      3:       return EmptyValue;
      default: return cdq_data_t'($urandom);
    endcase
  endfunction

  // Reports, refused pops and the unused command codes on an empty deque.
  task automatic test_empty_deque();
    send_command(CMD_REPORT, pick_value());
    send_command(CMD_POP_FRONT, pick_value());
    send_command(CMD_POP_REAR, pick_value());
    for (int c = CMD_REPORT + 1; c < (1 << CmdW); c++)
      send_command(CmdW'(c), pick_value());
  endtask

  // Extreme words at both ends, then a drain that ends with a pop of the last element.
  task automatic test_value_extremes();
    send_command(CMD_PUSH_FRONT, cdq_data_t'(32'h8000_0000));
    send_command(CMD_PUSH_REAR, cdq_data_t'(32'h7fff_ffff));
    send_command(CMD_PUSH_FRONT, '0);
    send_command(CMD_PUSH_REAR, EmptyValue);
    send_command(CMD_REPORT, '0);
    send_command(CMD_POP_FRONT, '0);
    send_command(CMD_POP_REAR, '0);
    send_command(CMD_POP_FRONT, '0);
    send_command(CMD_POP_REAR, '0);
    send_command(CMD_POP_REAR, '0);
    send_command(CMD_PUSH_REAR, cdq_data_t'(32'h5555_aaaa));
    send_command(CMD_POP_FRONT, '0);
  endtask

  // Starts a receiver hold-off, fills the deque past full, then drains it from both ends.
  task automatic test_fill_and_drain();
    -> start_hold;
    for (int i = 0; i < DefaultDepth + 3; i++)
      send_command($urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_REAR, pick_value());
    send_command(CMD_REPORT, '0);
    for (int i = 0; i < DefaultDepth + 2; i++)
      send_command(i[0] ? CMD_POP_FRONT : CMD_POP_REAR, '0);
  endtask

  // Random commands in segments that lean toward pushes or toward pops.
  task automatic test_random_traffic(int unsigned send_pct, int unsigned recv_pct, int n);
    int unsigned push_pct;
    int unsigned pick;
    logic [CmdW-1:0] c;
    send_gap_pct = send_pct;
    recv_gap_pct = recv_pct;
    for (int i = 0; i < n; i++) begin
      push_pct = ((i / 70) % 2 == 0) ? 78 : 17;
      pick = $urandom_range(99);
      if (pick < 5)
        c = CmdW'($urandom_range((1 << CmdW) - 1));
      else if (pick < 5 + push_pct)
        c = $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_REAR;
      else
        c = $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_REAR;
      send_command(c, pick_value());
    end
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.cmd   = CMD_REPORT;
    in_if.value = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_deque();
    test_value_extremes();
    test_fill_and_drain();
    test_random_traffic(6, 76, 140);
    test_random_traffic(76, 6, 140);
    test_random_traffic(0, 0, 140);
    stop_sending();

    while (expected_views.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("circular_deque_unit: match");
    end else begin
      $display("circular_deque_unit: mismatch");
    end
    $finish;
  end

endmodule
